// File: design/txtcon_pkg.sv
// shared types and constants of the text console writer
package txtcon_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam logic [15:0] BLANK_CELL = 16'h0020;  // space, attribute zero
    localparam logic [7:0]  BS_CHAR    = 8'h08;

    typedef enum logic [2:0] {
        CMD_PUT        = 3'd0,
        CMD_NEWLINE    = 3'd1,
        CMD_BACKSPACE  = 3'd2,
        CMD_CLEAR      = 3'd3,
        CMD_SET_CURSOR = 3'd4,
        CMD_READ       = 3'd5
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_FILL,
        ST_DRAIN,
        ST_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture the input transfer
        logic exec;        // apply the command to cursor and screen
        logic fill_start;  // arm the scroll or clear sweep
        logic fill_run;    // issue one cell of the sweep
        logic cell_load;   // capture read data for the result
    } ctl_t;

    // datapath to controller
    typedef struct packed {
        logic need_fill;
        logic is_read;
        logic fill_last;
    } sts_t;

endpackage

// File: design/txtcon_ram.sv
// generic single-write, single-read ram with registered read data
module txtcon_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: design/txtcon_ctrl.sv
// controller state machine of the text console writer
module txtcon_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  txtcon_pkg::sts_t  sts,
    output txtcon_pkg::ctl_t  ctl
);

    import txtcon_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctl        = '0;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                ctl.exec = 1'b1;
                if (sts.need_fill)
                begin
                    ctl.fill_start = 1'b1;
                    state_next     = ST_FILL;
                end
                else if (sts.is_read)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_READ:
            begin
                ctl.cell_load = 1'b1;
                state_next    = ST_DONE;
            end
            ST_FILL:
            begin
                ctl.fill_run = 1'b1;
                if (sts.fill_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // last delayed write of the sweep lands here
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                m_tvalid = 1'b1;
                if (m_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// File: design/txtcon_dp.sv
// datapath of the text console writer: cursor, screen ram and sweep engine
module txtcon_dp #(
    parameter int COLUMNS = txtcon_pkg::COLUMNS_DEF,
    parameter int ROWS    = txtcon_pkg::ROWS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  txtcon_pkg::ctl_t  ctl,
    output txtcon_pkg::sts_t  sts,
    input  logic [2:0]        in_command,
    input  logic [7:0]        in_char_code,
    input  logic [7:0]        in_attr,
    input  logic [4:0]        in_row,
    input  logic [6:0]        in_col,
    output logic [6:0]        cursor_col,
    output logic [4:0]        cursor_row,
    output logic [7:0]        cell_char,
    output logic [7:0]        cell_attr
);

    import txtcon_pkg::*;

    localparam int NCELLS = COLUMNS * ROWS;
    localparam int CW     = $clog2(COLUMNS);
    localparam int RW     = $clog2(ROWS);
    localparam int AW     = $clog2(NCELLS);

    localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
    localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
    localparam logic [AW-1:0] CELL_LAST = AW'(NCELLS - 1);
    localparam logic [AW-1:0] COPY_END  = AW'(NCELLS - COLUMNS);

    // captured input transfer
    logic [2:0]    cmd_reg;
    logic [7:0]    char_reg;
    logic [7:0]    attr_reg;
    logic [RW-1:0] row_clamp_reg;
    logic [CW-1:0] col_clamp_reg;

    logic [CW-1:0] cur_col_reg, cur_col_next;
    logic [RW-1:0] cur_row_reg, cur_row_next;
    logic [15:0]   cell_reg;

    // sweep engine
    logic [AW-1:0] ptr_reg;
    logic          fill_copy_reg;
    logic          pend_valid_reg;
    logic [AW-1:0] pend_addr_reg;
    logic          pend_copy_reg;

    logic is_put, is_bs, is_nl, is_clear, is_set, is_read;
    logic at_home, at_last_col, at_last_row;
    logic [AW-1:0] cur_addr, rd_addr_exec;
    logic [AW-1:0] src_addr;
    logic          copy_now;

    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [15:0]   ram_wdata, ram_rdata;

    logic [RW-1:0] row_clamp;
    logic [CW-1:0] col_clamp;

    assign row_clamp = (int'(in_row) > ROWS - 1)    ? ROW_LAST : RW'(in_row);
    assign col_clamp = (int'(in_col) > COLUMNS - 1) ? COL_LAST : CW'(in_col);

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg       <= in_command;
            char_reg      <= in_char_code;
            attr_reg      <= in_attr;
            row_clamp_reg <= row_clamp;
            col_clamp_reg <= col_clamp;
        end
        if (ctl.exec)
        begin
            cell_reg <= '0;
        end
        else if (ctl.cell_load)
        begin
            cell_reg <= ram_rdata;
        end
    end

    // decode
    assign is_put   = (cmd_reg == CMD_PUT) && (char_reg != BS_CHAR);
    assign is_bs    = (cmd_reg == CMD_BACKSPACE) ||
                      ((cmd_reg == CMD_PUT) && (char_reg == BS_CHAR));
    assign is_nl    = (cmd_reg == CMD_NEWLINE);
    assign is_clear = (cmd_reg == CMD_CLEAR);
    assign is_set   = (cmd_reg == CMD_SET_CURSOR);
    assign is_read  = (cmd_reg == CMD_READ);

    assign at_last_col = (cur_col_reg == COL_LAST);
    assign at_last_row = (cur_row_reg == ROW_LAST);
    assign at_home     = (cur_col_reg == '0) && (cur_row_reg == '0);

    assign cur_addr     = AW'(cur_row_reg) * AW'(COLUMNS) + AW'(cur_col_reg);
    assign rd_addr_exec = AW'(row_clamp_reg) * AW'(COLUMNS) + AW'(col_clamp_reg);

    assign sts.need_fill = is_clear || (is_put && at_last_col && at_last_row) ||
                           (is_nl && at_last_row);
    assign sts.is_read   = is_read;
    assign sts.fill_last = (ptr_reg == CELL_LAST);

    // cursor update
    always_comb
    begin
        cur_col_next = cur_col_reg;
        cur_row_next = cur_row_reg;
        if (ctl.exec)
        begin
            if (is_put)
            begin
                if (!at_last_col)
                begin
                    cur_col_next = cur_col_reg + 1'b1;
                end
                else
                begin
                    cur_col_next = '0;
                    if (!at_last_row)
                    begin
                        cur_row_next = cur_row_reg + 1'b1;
                    end
                end
            end
            else if (is_nl)
            begin
                cur_col_next = '0;
                if (!at_last_row)
                begin
                    cur_row_next = cur_row_reg + 1'b1;
                end
            end
            else if (is_bs)
            begin
                if (cur_col_reg != '0)
                begin
                    cur_col_next = cur_col_reg - 1'b1;
                end
                else if (cur_row_reg != '0)
                begin
                    cur_row_next = cur_row_reg - 1'b1;
                    cur_col_next = COL_LAST;
                end
            end
            else if (is_clear)
            begin
                cur_col_next = '0;
                cur_row_next = '0;
            end
            else if (is_set)
            begin
                cur_col_next = col_clamp_reg;
                cur_row_next = row_clamp_reg;
            end
        end
    end

    // sweep: read source now, write destination in the following cycle
    // source only used below COPY_END, so it stays inside the screen
    assign src_addr = ptr_reg + AW'(COLUMNS);
    assign copy_now = fill_copy_reg && (ptr_reg < COPY_END);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_col_reg    <= '0;
            cur_row_reg    <= '0;
            ptr_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            cur_col_reg    <= cur_col_next;
            cur_row_reg    <= cur_row_next;
            pend_valid_reg <= ctl.fill_run;
            if (ctl.fill_start)
            begin
                ptr_reg <= '0;
            end
            else if (ctl.fill_run && !sts.fill_last)
            begin
                ptr_reg <= ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.fill_start)
        begin
            fill_copy_reg <= !is_clear;
        end
        pend_addr_reg <= ptr_reg;
        pend_copy_reg <= copy_now;
    end

    // ram ports: sweep writes win, they never meet an exec write
    always_comb
    begin
        if (pend_valid_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = pend_addr_reg;
            ram_wdata = pend_copy_reg ? ram_rdata : BLANK_CELL;
        end
        else
        begin
            ram_we    = ctl.exec && (is_put || (is_bs && !at_home));
            ram_waddr = is_put ? cur_addr : cur_addr - 1'b1;
            ram_wdata = is_put ? {attr_reg, char_reg} : BLANK_CELL;
        end
    end

    always_comb
    begin
        if (ctl.fill_run)
        begin
            ram_raddr = copy_now ? src_addr : ptr_reg;
        end
        else
        begin
            ram_raddr = rd_addr_exec;
        end
    end

    txtcon_ram #(
        .WIDTH (16),
        .DEPTH (NCELLS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign cursor_col = 7'(cur_col_reg);
    assign cursor_row = 5'(cur_row_reg);
    assign cell_char  = cell_reg[7:0];
    assign cell_attr  = cell_reg[15:8];

endmodule

// File: design/text_console_writer.sv
// Text console writer: a COLUMNS x ROWS screen of 16-bit cells (character in the low
// byte, attribute in the high byte) with a cursor, driven one command per input transfer
// and answering with exactly one result transfer carrying the cursor and, for a read, the
// cell. Commands are taken one at a time; put char, newline, backspace, set cursor and
// unused commands go from the execute state straight to the result state, and a read
// goes through a read state between the two.
// A scroll (put char on the last column of the bottom row, newline on the bottom row)
// and a clear sweep every cell of the screen ram through its single write port, one cell
// a cycle, then a drain state lands the last write before the result is offered.
// The screen holds garbage after reset: issue a clear first.
module text_console_writer #(
    parameter int COLUMNS = txtcon_pkg::COLUMNS_DEF,
    parameter int ROWS    = txtcon_pkg::ROWS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // char_code[7:0], attr[15:8], row[20:16], col[27:21]
    input  logic [2:0]  s_tuser,   // command[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // cursor_col[6:0], cursor_row[11:7], cell_char[19:12],
                                   // cell_attr[27:20]
);

    import txtcon_pkg::*;

    ctl_t ctl;
    sts_t sts;

    logic [6:0] cursor_col;
    logic [4:0] cursor_row;
    logic [7:0] cell_char;
    logic [7:0] cell_attr;

    txtcon_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .ctl      (ctl)
    );

    txtcon_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sts          (sts),
        .in_command   (s_tuser),
        .in_char_code (s_tdata[7:0]),
        .in_attr      (s_tdata[15:8]),
        .in_row       (s_tdata[20:16]),
        .in_col       (s_tdata[27:21]),
        .cursor_col   (cursor_col),
        .cursor_row   (cursor_row),
        .cell_char    (cell_char),
        .cell_attr    (cell_attr)
    );

    assign m_tdata = {4'b0, cell_attr, cell_char, cursor_row, cursor_col};

    // one command in flight: no new transfer while a result is offered
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input accepted while result pending");

    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transfer taken before the first completed");

    a_sweep_done: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !ctl.fill_run)
        else $error("result offered while the screen sweep runs");

    a_cursor_col: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (int'(m_tdata[6:0]) < COLUMNS))
        else $error("cursor column off screen");

endmodule
